@@ hdl/sme_pkg.sv @@
// Package: constants, opcodes, status codes for the stack machine execute unit.
`default_nettype none
package sme_pkg;
   localparam int STACK_DEPTH = 1024;
   localparam int FRAME_DEPTH = 64;
   localparam int PROG_DEPTH  = 4096;
   localparam int WORD_WIDTH  = 32;
   localparam int SA_W = $clog2(STACK_DEPTH);
   localparam int SP_W = SA_W + 1;
   localparam int FA_W = $clog2(FRAME_DEPTH);
   localparam int FC_W = FA_W + 1;
   localparam int PC_W = 12;
   localparam int PL_W = 13;

   typedef logic [WORD_WIDTH-1:0] word_type;

   typedef enum logic [4:0] {
      OP_NOP = 5'd0, OP_ERR = 5'd1, OP_PUSHI = 5'd2, OP_PUSHG = 5'd3, OP_PUSHL = 5'd4,
      OP_PUSHN = 5'd5, OP_POPN = 5'd6, OP_STOREL = 5'd7, OP_STOREG = 5'd8,
      OP_DUPN = 5'd9, OP_JUMP = 5'd10, OP_JZ = 5'd11, OP_CALL = 5'd12, OP_RET = 5'd13,
      OP_ADD = 5'd14, OP_SUB = 5'd15, OP_MUL = 5'd16, OP_DIV = 5'd17, OP_INF = 5'd18,
      OP_INFEQ = 5'd19, OP_SUP = 5'd20, OP_SUPEQ = 5'd21, OP_WRITEI = 5'd22,
      OP_EQUAL = 5'd23, OP_NOT = 5'd24, OP_START = 5'd25, OP_STOP = 5'd26,
      OP_PUSHA = 5'd27, OP_SWAP = 5'd28
   } op_type;

   localparam logic [3:0] ST_OK = 4'd0, ST_STOP = 4'd1, ST_ERR = 4'd2, ST_OVF = 4'd3,
      ST_UNF = 4'd4, ST_NEG = 4'd5, ST_OUT = 4'd6, ST_LOC = 4'd7, ST_START2 = 4'd8,
      ST_RET = 4'd9, ST_CALLST = 4'd10, ST_DIV0 = 4'd11, ST_END = 4'd12,
      ST_FFULL = 4'd13, ST_CTGT = 4'd14;

   // ALU operations of the shared unit
   typedef enum logic [3:0] {
      ALU_ADD, ALU_SUB, ALU_MUL, ALU_LT, ALU_LE, ALU_GT, ALU_GE, ALU_EQ, ALU_NOT, ALU_PASS
   } alu_op_type;
endpackage
`default_nettype wire

@@ hdl/sme_if.sv @@
// Valid/ready channel interfaces for requests and responses.
`default_nettype none
interface sme_req_if import sme_pkg::*; ();
   logic valid;
   logic ready;
   logic [4:0] cmd;
   logic signed [31:0] arg;
   logic [11:0] target;
   modport source (output valid, cmd, arg, target, input ready);
   modport sink (input valid, cmd, arg, target, output ready);
endinterface

interface sme_rsp_if import sme_pkg::*; ();
   logic valid;
   logic ready;
   logic [11:0] next_pc;
   logic [3:0] status;
   logic print_valid;
   logic signed [31:0] print_value;
   modport source (output valid, next_pc, status, print_valid, print_value, input ready);
   modport sink (input valid, next_pc, status, print_valid, print_value, output ready);
endinterface
`default_nettype wire

@@ hdl/sme_alu.sv @@
// Shared ALU with a registered result: add, sub, 32x32 multiply, compares, not.
`default_nettype none
module sme_alu import sme_pkg::*; (
   input  wire        clock,
   input  alu_op_type op,
   input  word_type   a,
   input  word_type   b,
   output word_type   result_ff
);
   word_type result_in;
   logic lt, eq;
   always_comb begin
      lt = $signed(a) < $signed(b);
      eq = a == b;
      case (op)
         ALU_ADD: result_in = a + b;
         ALU_SUB: result_in = a - b;
         ALU_MUL: result_in = a * b;
         ALU_LT:  result_in = word_type'(lt);
         ALU_LE:  result_in = word_type'(lt | eq);
         ALU_GT:  result_in = word_type'(!(lt | eq));
         ALU_GE:  result_in = word_type'(!lt);
         ALU_EQ:  result_in = word_type'(eq);
         ALU_NOT: result_in = word_type'(a == '0);
         default: result_in = a;
      endcase
   end
   always_ff @(posedge clock) result_ff <= result_in;
endmodule
`default_nettype wire

@@ hdl/sme_div.sv @@
// Radix-2 restoring divider, signed truncating, one quotient bit a cycle.
`default_nettype none
module sme_div import sme_pkg::*; (
   input  wire      clock,
   input  wire      reset,
   input  wire      start,
   input  word_type dividend,
   input  word_type divisor,
   output logic     done,
   output word_type quotient
);
   localparam int CW = $clog2(WORD_WIDTH + 1);
   word_type rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [WORD_WIDTH:0] trial;
   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff; neg_in = neg_ff;
      busy_in = busy_ff; cnt_in = cnt_ff; done_in = 1'b0;
      trial = {rem_ff, quo_ff[WORD_WIDTH-1]} - {1'b0, den_ff};
      if (start) begin
         rem_in = '0;
         quo_in = dividend[WORD_WIDTH-1] ? -dividend : dividend;
         den_in = divisor[WORD_WIDTH-1] ? -divisor : divisor;
         neg_in = dividend[WORD_WIDTH-1] ^ divisor[WORD_WIDTH-1];
         busy_in = 1'b1;
         cnt_in = CW'(WORD_WIDTH);
      end else if (busy_ff) begin
         if (!trial[WORD_WIDTH]) begin
            rem_in = trial[WORD_WIDTH-1:0];
            quo_in = {quo_ff[WORD_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[WORD_WIDTH-2:0], quo_ff[WORD_WIDTH-1]};
            quo_in = {quo_ff[WORD_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in; quo_ff <= quo_in; den_ff <= den_in; neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end
   assign done = done_ff;
   assign quotient = neg_ff ? -quo_ff : quo_ff;
endmodule
`default_nettype wire

@@ hdl/stack_machine_execute_unit.sv @@
// Stack machine execute unit: top level with sequencer, stack and frame memories.
// Usage:
//  req channel carries one instruction (cmd, arg, target) fetched at the
//  current pc; rsp channel returns next_pc, status and an optional print.
//  csr_write_enable/csr_write_data set program_length while idle.
//  For most ops the result is valid after the req transfer once two stack
//  memory reads (one read port, registered) and execute are done.
//  Arithmetic, compares and not add an ALU pass and a writeback; swap adds
//  a writeback. The block then passes through the response state to idle
//  before it takes the next req transfer. div waits in the radix-2 divider
//  in place of the ALU pass and writeback; pushn writes n zero words in a
//  fill state, and dupn copies n words with a read and a write state each.
//  The block accepts one instruction at a time; req_ready is high only in
//  idle. A finished result sits in the output register until taken; a
//  stalled receiver holds the block in that state.
//  After reset a clearing pass writes zero to every stack word, one per
//  cycle, with req_ready low. Faults latch a sticky code; later
//  instructions return the same pc and code with no state change.
`default_nettype none
module stack_machine_execute_unit import sme_pkg::*; (
   input  wire              clock,
   input  wire              reset,
   sme_req_if.sink          req,
   sme_rsp_if.source        rsp,
   input  wire              csr_write_enable,
   input  wire [PL_W-1:0]   csr_write_data
);
   typedef enum logic [11:0] {
      S_CLEAR = 12'b000000000001, S_IDLE = 12'b000000000010,
      S_RD1   = 12'b000000000100, S_RD2  = 12'b000000001000,
      S_EXEC  = 12'b000000010000, S_ALU  = 12'b000000100000,
      S_DIV   = 12'b000001000000, S_WB   = 12'b000010000000,
      S_FILL  = 12'b000100000000, S_DUP  = 12'b001000000000,
      S_DUPW  = 12'b010000000000, S_RESP = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   word_type mem [STACK_DEPTH];
   logic mem_we;
   logic [SA_W-1:0] mem_wa, mem_ra;
   word_type mem_wd, rdata_ff;

   logic [FA_W-1:0] fr_wa, fr_ra;
   logic fr_we;
   logic [SP_W+PC_W-1:0] frames [FRAME_DEPTH];
   logic [SP_W+PC_W-1:0] fr_wd, fr_rd_ff;

   logic [SP_W-1:0] sp_ff, sp_in, fp_ff, fp_in;
   logic fv_ff, fv_in;
   logic [FC_W-1:0] fc_ff, fc_in;
   logic [PC_W-1:0] pc_ff, pc_in, npc_ff, npc_in;
   logic [3:0] halt_ff, halt_in, st_ff, st_in;
   logic [PL_W-1:0] plen_ff;
   op_type op_ff, op_in;
   word_type arg_ff, arg_in, x_ff, x_in, y_ff, y_in;
   logic [PC_W-1:0] tgt_ff, tgt_in;
   logic [SA_W:0] cnt_ff, cnt_in;
   logic [SA_W-1:0] clr_ff, clr_in;
   logic pv_ff, pv_in;
   word_type pval_ff, pval_in;

   alu_op_type alu_op;
   word_type alu_res;
   logic div_start, div_done;
   word_type div_q;

   sme_alu u_alu (.clock(clock), .op(alu_op), .a(x_ff), .b(y_ff), .result_ff(alu_res));
   sme_div u_div (.clock(clock), .reset(reset), .start(div_start), .dividend(x_ff),
      .divisor(y_ff), .done(div_done), .quotient(div_q));

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rdata_ff <= mem[mem_ra];
      if (fr_we) frames[fr_wa] <= fr_wd;
      fr_rd_ff <= frames[fr_ra];
   end

   logic [PL_W-1:0] limit;
   logic signed [SP_W+32:0] idx;
   logic signed [33:0] sarg;
   logic [PL_W-1:0] pc_ext;
   logic two_ok, one_ok;

   assign limit = (plen_ff > PL_W'(PROG_DEPTH)) ? PL_W'(PROG_DEPTH) : plen_ff;

   always_comb begin
      state_in = state_ff; sp_in = sp_ff; fp_in = fp_ff; fv_in = fv_ff; fc_in = fc_ff;
      pc_in = pc_ff; npc_in = npc_ff; halt_in = halt_ff; st_in = st_ff;
      op_in = op_ff; arg_in = arg_ff; x_in = x_ff; y_in = y_ff; tgt_in = tgt_ff;
      cnt_in = cnt_ff; clr_in = clr_ff; pv_in = pv_ff; pval_in = pval_ff;
      mem_we = 1'b0; mem_wa = sp_ff[SA_W-1:0]; mem_wd = '0;
      mem_ra = SA_W'(sp_ff - 1'b1);
      fr_we = 1'b0; fr_wa = fc_ff[FA_W-1:0]; fr_wd = {fp_ff, pc_ff};
      fr_ra = FA_W'(fc_ff - 1'b1);
      alu_op = ALU_PASS; div_start = 1'b0;
      sarg = 34'(signed'(arg_ff));
      idx = (op_ff == OP_PUSHL || op_ff == OP_STOREL) ?
         (SP_W+33)'(signed'({1'b0, fp_ff})) + (SP_W+33)'(sarg) : (SP_W+33)'(sarg);
      pc_ext = PL_W'(pc_ff);
      one_ok = sp_ff >= SP_W'(1);
      two_ok = sp_ff >= SP_W'(2);
      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1; mem_wa = clr_ff; mem_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SA_W'(STACK_DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req.valid) begin
               op_in = op_type'(req.cmd); arg_in = word_type'(req.arg);
               tgt_in = req.target; pv_in = 1'b0; pval_in = '0;
               npc_in = pc_ff + 1'b1; st_in = ST_OK;
               state_in = S_RD1;
            end
         end
         S_RD1: begin
            // read top of stack (or the addressed word for pushg/pushl)
            mem_ra = SA_W'(sp_ff - 1'b1);
            if (op_ff == OP_PUSHG || op_ff == OP_PUSHL) mem_ra = idx[SA_W-1:0];
            state_in = S_RD2;
         end
         S_RD2: begin
            y_in = rdata_ff; x_in = rdata_ff;
            mem_ra = SA_W'(sp_ff - 2'd2);
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
            if (halt_ff != ST_OK) begin
               st_in = halt_ff; npc_in = pc_ff;
            end else if (pc_ext >= limit) begin
               st_in = ST_END;
            end else begin
               case (op_ff)
                  OP_ERR: st_in = ST_ERR;
                  OP_STOP: st_in = ST_STOP;
                  OP_PUSHI, OP_PUSHA: begin
                     if (sp_ff >= SP_W'(STACK_DEPTH)) st_in = ST_OVF;
                     else begin
                        mem_we = 1'b1;
                        mem_wd = (op_ff == OP_PUSHI) ? arg_ff : word_type'(tgt_ff);
                        sp_in = sp_ff + 1'b1;
                     end
                  end
                  OP_PUSHG, OP_PUSHL: begin
                     if (sp_ff >= SP_W'(STACK_DEPTH)) st_in = ST_OVF;
                     else if (op_ff == OP_PUSHL && !fv_ff) st_in = ST_LOC;
                     else if (idx < 0 || idx >= STACK_DEPTH) st_in = ST_OUT;
                     else begin
                        mem_we = 1'b1; mem_wd = y_ff; sp_in = sp_ff + 1'b1;
                     end
                  end
                  OP_PUSHN: begin
                     if (sarg < 0) st_in = ST_NEG;
                     else if (34'(sp_ff) + sarg > STACK_DEPTH) st_in = ST_OVF;
                     else begin
                        cnt_in = (SA_W+1)'(arg_ff); state_in = S_FILL;
                     end
                  end
                  OP_POPN: begin
                     if (sarg < 0) st_in = ST_NEG;
                     else if (34'(sp_ff) < sarg) st_in = ST_UNF;
                     else sp_in = sp_ff - SP_W'(arg_ff);
                  end
                  OP_DUPN: begin
                     if (sarg < 0) st_in = ST_NEG;
                     else if (34'(sp_ff) + sarg > STACK_DEPTH) st_in = ST_OVF;
                     else if (34'(sp_ff) < sarg) st_in = ST_OUT;
                     else begin
                        cnt_in = (SA_W+1)'(arg_ff); state_in = S_DUP;
                     end
                  end
                  OP_STOREL, OP_STOREG: begin
                     if (!one_ok) st_in = ST_UNF;
                     else if (op_ff == OP_STOREL && !fv_ff) st_in = ST_LOC;
                     else if (idx < 0 || idx >= STACK_DEPTH) st_in = ST_OUT;
                     else begin
                        mem_we = 1'b1; mem_wa = idx[SA_W-1:0]; mem_wd = y_ff;
                        sp_in = sp_ff - 1'b1;
                     end
                  end
                  OP_JUMP: npc_in = tgt_ff;
                  OP_JZ: begin
                     if (!one_ok) st_in = ST_UNF;
                     else begin
                        sp_in = sp_ff - 1'b1;
                        if (y_ff == '0) npc_in = tgt_ff;
                     end
                  end
                  OP_CALL: begin
                     if (!one_ok) st_in = ST_UNF;
                     else if (!fv_ff) st_in = ST_CALLST;
                     else if (fc_ff >= FC_W'(FRAME_DEPTH)) st_in = ST_FFULL;
                     else if (y_ff >= word_type'(limit)) st_in = ST_CTGT;
                     else begin
                        fr_we = 1'b1; fc_in = fc_ff + 1'b1;
                        sp_in = sp_ff - 1'b1; fp_in = sp_ff - 1'b1;
                        npc_in = y_ff[PC_W-1:0];
                     end
                  end
                  OP_RET: begin
                     if (fc_ff == '0) st_in = ST_RET;
                     else begin
                        fc_in = fc_ff - 1'b1; sp_in = fp_ff;
                        fp_in = fr_rd_ff[SP_W+PC_W-1:PC_W];
                        npc_in = fr_rd_ff[PC_W-1:0] + 1'b1;
                     end
                  end
                  OP_ADD, OP_SUB, OP_MUL, OP_INF, OP_INFEQ, OP_SUP, OP_SUPEQ, OP_EQUAL,
                  OP_DIV: begin
                     if (!two_ok) st_in = ST_UNF;
                     else if (op_ff == OP_DIV && y_ff == '0) st_in = ST_DIV0;
                     else begin
                        x_in = rdata_ff; state_in = (op_ff == OP_DIV) ? S_DIV : S_ALU;
                     end
                  end
                  OP_NOT: begin
                     if (!one_ok) st_in = ST_UNF;
                     else state_in = S_ALU;
                  end
                  OP_WRITEI: begin
                     if (!one_ok) st_in = ST_UNF;
                     else begin
                        sp_in = sp_ff - 1'b1; pv_in = 1'b1; pval_in = y_ff;
                     end
                  end
                  OP_START: begin
                     if (fv_ff) st_in = ST_START2;
                     else begin
                        fv_in = 1'b1; fp_in = sp_ff;
                     end
                  end
                  OP_SWAP: begin
                     if (!two_ok) st_in = ST_UNF;
                     else begin
                        mem_we = 1'b1; mem_wa = SA_W'(sp_ff - 1'b1); mem_wd = rdata_ff;
                        x_in = rdata_ff; state_in = S_WB;
                     end
                  end
                  default: ;
               endcase
            end
            if (halt_ff == ST_OK && st_in != ST_OK) begin
               // fault: undo state changes in this cycle
               mem_we = 1'b0; fr_we = 1'b0; sp_in = sp_ff; fp_in = fp_ff; fv_in = fv_ff;
               fc_in = fc_ff; halt_in = st_in; npc_in = pc_ff; pv_in = 1'b0;
               pval_in = '0; state_in = S_RESP;
            end
         end
         S_ALU: begin
            // x is lower operand, y top; not uses top only
            case (op_ff)
               OP_ADD: alu_op = ALU_ADD;
               OP_SUB: alu_op = ALU_SUB;
               OP_MUL: alu_op = ALU_MUL;
               OP_INF: alu_op = ALU_LT;
               OP_INFEQ: alu_op = ALU_LE;
               OP_SUP: alu_op = ALU_GT;
               OP_SUPEQ: alu_op = ALU_GE;
               OP_EQUAL: alu_op = ALU_EQ;
               OP_NOT: alu_op = ALU_NOT;
               default: alu_op = ALU_PASS;
            endcase
            if (op_ff == OP_NOT) x_in = y_ff;
            state_in = S_WB;
            if (op_ff == OP_NOT && x_ff != y_ff) state_in = S_ALU;
         end
         S_DIV: begin
            div_start = (cnt_ff == '0);
            cnt_in = {{SA_W{1'b0}}, 1'b1};
            if (div_done) begin
               mem_we = 1'b1; mem_wa = SA_W'(sp_ff - 2'd2); mem_wd = div_q;
               sp_in = sp_ff - 1'b1; cnt_in = '0; state_in = S_RESP;
            end
         end
         S_WB: begin
            if (op_ff == OP_SWAP) begin
               mem_we = 1'b1; mem_wa = SA_W'(sp_ff - 2'd2); mem_wd = y_ff;
            end else if (op_ff == OP_NOT) begin
               mem_we = 1'b1; mem_wa = SA_W'(sp_ff - 1'b1); mem_wd = alu_res;
            end else begin
               mem_we = 1'b1; mem_wa = SA_W'(sp_ff - 2'd2); mem_wd = alu_res;
               sp_in = sp_ff - 1'b1;
            end
            state_in = S_RESP;
         end
         S_FILL: begin
            if (cnt_ff == '0) state_in = S_RESP;
            else begin
               mem_we = 1'b1; mem_wd = '0; sp_in = sp_ff + 1'b1; cnt_in = cnt_ff - 1'b1;
            end
         end
         S_DUP: begin
            // read source word sp - arg, copy lands at sp
            mem_ra = SA_W'(sp_ff - SP_W'(arg_ff));
            if (cnt_ff == '0) state_in = S_RESP;
            else state_in = S_DUPW;
         end
         S_DUPW: begin
            mem_we = 1'b1; mem_wd = rdata_ff; sp_in = sp_ff + 1'b1;
            cnt_in = cnt_ff - 1'b1; state_in = S_DUP;
         end
         S_RESP: begin
            if (rsp.ready) begin
               if (st_ff == ST_OK) pc_in = npc_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; sp_ff <= '0; fp_ff <= '0; fv_ff <= 1'b0;
         fc_ff <= '0; pc_ff <= '0; halt_ff <= ST_OK; plen_ff <= '0; cnt_ff <= '0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; sp_ff <= sp_in; fp_ff <= fp_in;
         fv_ff <= fv_in; fc_ff <= fc_in; pc_ff <= pc_in; halt_ff <= halt_in;
         cnt_ff <= cnt_in;
         if (csr_write_enable) plen_ff <= csr_write_data;
      end
      op_ff <= op_in; arg_ff <= arg_in; x_ff <= x_in; y_ff <= y_in; tgt_ff <= tgt_in;
      npc_ff <= npc_in; st_ff <= st_in; pv_ff <= pv_in; pval_ff <= pval_in;
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_RESP);
   assign rsp.next_pc = npc_ff;
   assign rsp.status = st_ff;
   assign rsp.print_valid = pv_ff;
   assign rsp.print_value = pval_ff;

   a_one_state: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_sticky: assert property (@(posedge clock) disable iff (reset)
      ($past(halt_ff) != ST_OK && !$past(reset)) |-> $stable(halt_ff))
      else $error("halt code changed");
   a_fault_pc: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status != ST_OK) |-> (rsp.next_pc == pc_ff && !rsp.print_valid))
      else $error("fault response pc mismatch");
   a_sp_range: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("stack pointer out of range");
endmodule
`default_nettype wire
